// ===== hdl/asymmetric_hampel_outlier_gate_assert.svh =====
// Assertion helpers for the outlier gate, clocked on i_clk and held off in reset.
`ifndef ASYMMETRIC_HAMPEL_OUTLIER_GATE_ASSERT_SVH
`define ASYMMETRIC_HAMPEL_OUTLIER_GATE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define AHOG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ahog assertion failed");

// Check that cons holds in the cycle after ante.
`define AHOG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ahog assertion failed");

`endif

// ===== hdl/ahog_pkg.sv =====
package ahog_pkg;

    // Default sizes
    localparam int DEF_WINDOW   = 16;
    localparam int DEF_CHANNELS = 4;
    localparam int NUM_IN_CH    = 4;

    // 1.4826 in Q16
    localparam logic [16:0] SIGMA_K_Q16 = 17'd97163;

    // Register indexes
    localparam logic [2:0] CFG_LIMIT_CH0 = 3'd0;
    localparam logic [2:0] CFG_LIMIT_CH1 = 3'd1;
    localparam logic [2:0] CFG_LIMIT_CH2 = 3'd2;
    localparam logic [2:0] CFG_LIMIT_CH3 = 3'd3;
    localparam logic [2:0] CFG_GAIN_UP   = 3'd4;
    localparam logic [2:0] CFG_GAIN_LO   = 3'd5;
    localparam logic [2:0] CFG_FLOOR     = 3'd6;
    localparam logic [2:0] CFG_WARMUP    = 3'd7;

    // Register reset values
    localparam logic [11:0] RST_GAIN   = 12'd768;
    localparam logic [14:0] RST_FLOOR  = 15'd50;
    localparam logic [4:0]  RST_WARMUP = 5'd8;

    // Reject causes
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_RANGE = 2'd1;
    localparam logic [1:0] CAUSE_BOUND = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GATE,
        ST_NEXT,
        ST_CRD,
        ST_CGET,
        ST_SRD,
        ST_SGET,
        ST_CHK,
        ST_SIG,
        ST_PROD,
        ST_CMP,
        ST_UPD,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/asymmetric_hampel_outlier_gate.sv =====
// Asymmetric Hampel outlier gate. Takes one set of up to four signed distances with a
// presence mask, checks each present channel against its nonzero absolute range limit, then
// tests every present channel whose window holds at least warmup_count samples against
// median - gain_lower*sigma .. median + gain_upper*sigma, sigma = max(1.4826*MAD, floor).
// A set that passes is accepted and its present values are pushed into the windows.
// One set is handled at a time and s_axis_tready is low until its result is taken.
// Steps per set: the range gate, a scan over the channels with a median and MAD search for
// each tested channel, the window update of each channel, then the result, held until
// m_axis_tready; a rejected set goes straight to the result. Median and MAD are found by
// rank counting on one shared compare unit fed by the single read port of the sample
// memory; each compare needs a memory read of its own.
module asymmetric_hampel_outlier_gate #(
    parameter int WINDOW   = ahog_pkg::DEF_WINDOW,
    parameter int CHANNELS = ahog_pkg::DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // td_ch0, td_ch1, td_ch2, td_ch3 (16 bits each, from bit 0 up)
    input  logic [63:0] s_axis_tdata,
    // present_mask
    input  logic [3:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accepted, reject_cause[1:0], reject_channel[1:0], zero pad
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ahog_pkg::*;

    localparam int ACTIVE = (CHANNELS < NUM_IN_CH) ? CHANNELS : NUM_IN_CH;
    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHW    = $clog2(ACTIVE + 1);
    localparam int IW     = $clog2(WINDOW);
    localparam int FW     = $clog2(WINDOW + 1);
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int AW     = $clog2(DEPTH);

    // Configuration
    logic [15:0] r_limit [NUM_IN_CH];
    logic [11:0] r_gain_up, r_gain_lo;
    logic [14:0] r_floor;
    logic [4:0]  r_warm;

    // Window state
    logic [FW-1:0] r_fill [CHANNELS];
    logic [IW-1:0] r_head [CHANNELS];
    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] r_rdata;

    // Item and working registers
    t_state r_state, n_state;
    logic signed [15:0] r_td [NUM_IN_CH];
    logic [3:0]    r_mask;
    logic [CHW-1:0] r_ch;
    logic          r_pass;
    logic [FW-1:0] r_i, r_j, r_lt, r_le;
    logic signed [17:0] r_cand;
    logic signed [15:0] r_med;
    logic [16:0]   r_mad;
    logic [33:0]   r_sig;
    logic signed [16:0] r_diff;
    logic [15:0]   r_dmag;
    logic [45:0]   r_prod;
    logic          r_ovalid, r_acc;
    logic [1:0]    r_cause, r_rch;

    // Combinational helpers
    logic [CW-1:0]  w_ch;
    logic [1:0]     w_tdi;
    logic [FW-1:0]  w_n, w_k;
    logic signed [15:0] w_td;
    logic           w_test, w_found, w_last, w_bound_fail, w_upd_last, w_scan_end;
    logic           w_gate_fail;
    logic [1:0]     w_gate_ch;
    logic signed [16:0] w_dev;
    logic [16:0]    w_adev;
    logic signed [17:0] w_rkey;
    logic [33:0]    w_mad_k, w_floor_q;
    logic [11:0]    w_gain;
    logic [IW-1:0]  w_idx;
    logic [AW-1:0]  w_addr;
    logic           w_we;
    logic [15:0]    w_mag [NUM_IN_CH];

    assign w_ch   = CW'(r_ch);
    assign w_tdi  = 2'(r_ch);
    assign w_td   = r_td[w_tdi];
    assign w_n    = r_fill[w_ch];
    assign w_k    = w_n >> 1;
    assign w_test = r_mask[w_tdi] && (8'(r_fill[w_ch]) >= 8'(r_warm));
    assign w_found = (r_lt <= w_k) && (w_k < r_le);
    assign w_last  = (r_j == w_n - FW'(1));
    assign w_scan_end = (r_ch == CHW'(ACTIVE));
    assign w_upd_last = (r_ch == CHW'(ACTIVE - 1));
    assign w_bound_fail = (r_diff != 17'sd0) && (46'({r_dmag, 24'd0}) > r_prod);

    // Sort key: raw sample for the median pass, distance from median for MAD
    assign w_dev  = 17'(r_rdata) - 17'(r_med);
    assign w_adev = w_dev[16] ? 17'(-w_dev) : w_dev;
    assign w_rkey = r_pass ? 18'({1'b0, w_adev}) : 18'(r_rdata);

    assign w_mad_k   = 34'(r_mad) * 34'(SIGMA_K_Q16);
    assign w_floor_q = 34'({r_floor, 16'd0});
    assign w_gain    = (!r_diff[16] && r_diff != 17'sd0) ? r_gain_up : r_gain_lo;

    // Range gate: first present channel above its nonzero limit
    always_comb begin
        w_gate_fail = 1'b0;
        w_gate_ch   = 2'd0;
        for (int c = NUM_IN_CH - 1; c >= 0; c--) begin
            w_mag[c] = r_td[c][15] ? 16'(-r_td[c]) : r_td[c];
            if (c < ACTIVE && r_mask[c] && r_limit[c] != 16'd0 && w_mag[c] > r_limit[c]) begin
                w_gate_fail = 1'b1;
                w_gate_ch   = 2'(c);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_GATE;
            ST_GATE: n_state = w_gate_fail ? ST_OUT : ST_NEXT;
            ST_NEXT: begin
                if (w_scan_end) n_state = ST_UPD;
                else if (w_test) n_state = (w_n == FW'(0)) ? ST_SIG : ST_CRD;
            end
            ST_CRD:  n_state = ST_CGET;
            ST_CGET: n_state = ST_SRD;
            ST_SRD:  n_state = ST_SGET;
            ST_SGET: n_state = w_last ? ST_CHK : ST_SRD;
            ST_CHK:  n_state = (w_found && r_pass) ? ST_SIG : ST_CRD;
            ST_SIG:  n_state = ST_PROD;
            ST_PROD: n_state = ST_CMP;
            ST_CMP:  n_state = w_bound_fail ? ST_OUT : ST_NEXT;
            ST_UPD:  if (w_upd_last) n_state = ST_OUT;
            ST_OUT:  if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and memory control
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_CRD:  w_idx = IW'(r_i);
            ST_SRD:  w_idx = IW'(r_j);
            default: w_idx = r_head[w_ch];
        endcase
        w_we   = (r_state == ST_UPD) && r_mask[w_tdi];
        w_addr = AW'(int'(w_ch) * WINDOW + int'(w_idx));
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_rch, r_cause, r_acc};

    // Sample memory: one address a cycle, written and read together, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_addr] <= w_td;
        r_rdata <= mem[w_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_IN_CH; c++) r_limit[c] <= 16'd0;
            r_gain_up <= RST_GAIN;
            r_gain_lo <= RST_GAIN;
            r_floor   <= RST_FLOOR;
            r_warm    <= RST_WARMUP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIMIT_CH0: r_limit[0] <= i_cfg_data;
                CFG_LIMIT_CH1: r_limit[1] <= i_cfg_data;
                CFG_LIMIT_CH2: r_limit[2] <= i_cfg_data;
                CFG_LIMIT_CH3: r_limit[3] <= i_cfg_data;
                CFG_GAIN_UP:   r_gain_up  <= i_cfg_data[11:0];
                CFG_GAIN_LO:   r_gain_lo  <= i_cfg_data[11:0];
                CFG_FLOOR:     r_floor    <= i_cfg_data[14:0];
                CFG_WARMUP:    r_warm     <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill[c] <= '0;
                r_head[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state != ST_OUT && n_state == ST_OUT) r_ovalid <= 1'b1;
            // Advance head and fill of each present channel on accept
            if (w_we) begin
                r_head[w_ch] <= (r_head[w_ch] == IW'(WINDOW - 1)) ? '0 : r_head[w_ch] + IW'(1);
                if (r_fill[w_ch] != FW'(WINDOW)) r_fill[w_ch] <= r_fill[w_ch] + FW'(1);
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                for (int c = 0; c < NUM_IN_CH; c++) r_td[c] <= s_axis_tdata[16*c +: 16];
                r_mask <= s_axis_tuser;
            end
            ST_GATE: begin
                r_ch    <= '0;
                r_acc   <= 1'b0;
                r_cause <= CAUSE_RANGE;
                r_rch   <= w_gate_ch;
            end
            ST_NEXT: begin
                if (w_scan_end) begin
                    r_ch <= '0;
                end else if (w_test) begin
                    r_pass <= 1'b0;
                    r_i    <= '0;
                    r_med  <= 16'sd0;
                    r_mad  <= 17'd0;
                end else begin
                    r_ch <= r_ch + CHW'(1);
                end
            end
            ST_CGET: begin
                r_cand <= w_rkey;
                r_j    <= '0;
                r_lt   <= '0;
                r_le   <= '0;
            end
            // Count window keys below and not above the candidate
            ST_SGET: begin
                if (w_rkey < r_cand)  r_lt <= r_lt + FW'(1);
                if (w_rkey <= r_cand) r_le <= r_le + FW'(1);
                r_j <= r_j + FW'(1);
            end
            ST_CHK: begin
                if (w_found) begin
                    r_i <= '0;
                    if (r_pass) r_mad <= r_cand[16:0];
                    else        r_med <= r_cand[15:0];
                    r_pass <= 1'b1;
                end else begin
                    r_i <= r_i + FW'(1);
                end
            end
            ST_SIG: begin
                r_sig  <= (w_floor_q > w_mad_k) ? w_floor_q : w_mad_k;
                r_diff <= 17'(w_td) - 17'(r_med);
            end
            ST_PROD: begin
                r_prod <= w_gain * r_sig;
                r_dmag <= r_diff[16] ? 16'(-r_diff) : r_diff[15:0];
            end
            ST_CMP: begin
                r_acc   <= 1'b0;
                r_cause <= CAUSE_BOUND;
                r_rch   <= w_tdi;
                if (!w_bound_fail) r_ch <= r_ch + CHW'(1);
            end
            ST_UPD: begin
                r_acc   <= 1'b1;
                r_cause <= CAUSE_NONE;
                r_rch   <= 2'd0;
                r_ch    <= r_ch + CHW'(1);
            end
            default: ;
        endcase
    end

    `include "asymmetric_hampel_outlier_gate_assert.svh"

    `AHOG_ASSERT_SAME(a_one_side_busy, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `AHOG_ASSERT_SAME(a_acc_cause, m_axis_tvalid, r_acc == (r_cause == CAUSE_NONE))
    `AHOG_ASSERT_NEXT(a_take_to_gate, s_axis_tvalid && s_axis_tready, r_state == ST_GATE)
    `AHOG_ASSERT_SAME(a_fill_bound, 1'b1, r_fill[0] <= FW'(WINDOW))

endmodule
